FILE: design/vpr_pkg.sv
// Shared types, constants and helper functions of the vector polar/rectangular unit.
package vpr_pkg;

  localparam int EXTRA_BITS = 16;
  localparam int ROT_W = 50;
  localparam int VEC_W = 51;
  localparam int TURN_W = 34;
  localparam int ROOT_BITS = 32;

  localparam logic signed [33:0] GAIN_INV_Q32 = 34'sd2608131496;
  localparam logic signed [30:0] PI_Q28 = 31'sd843314857;
  localparam logic signed [TURN_W-1:0] TURN_HALF = 34'sd2147483648;
  localparam logic signed [TURN_W-1:0] TURN_QUARTER = 34'sd1073741824;

  localparam int DIV45_S1 = 35;
  localparam int DIV45_S2 = 36;
  localparam logic [29:0] DIV45_M1 = 30'(((64'd1 << DIV45_S1) / 45) + 64'd1);
  localparam logic [30:0] DIV45_M2 = 31'(((64'd1 << DIV45_S2) / 45) + 64'd1);

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_SAT = 2'd2;

  typedef enum logic [2:0] {
    REQ_RECT    = 3'd0,
    REQ_POLAR   = 3'd1,
    REQ_MAGANG  = 3'd2,
    REQ_ADD     = 3'd3,
    REQ_SUB     = 3'd4,
    REQ_NEG     = 3'd5,
    REQ_SCALE   = 3'd6,
    REQ_INVALID = 3'd7
  } req_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               over;
  } sat_t;

  typedef struct packed {
    logic                     bypass;
    logic                     bad;
    logic                     sat;
    logic signed [ROT_W-1:0]  x;
    logic signed [ROT_W-1:0]  y;
    logic signed [TURN_W-1:0] t;
  } rot_t;

  typedef struct packed {
    logic               bad;
    logic               sat;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } vec_t;

  function automatic sat_t clamp32(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'sd2147483647) begin
      r.val = 32'sh7fffffff;
      r.over = 1'b1;
    end else if (v < -64'sd2147483648) begin
      r.val = 32'sh80000000;
      r.over = 1'b1;
    end else begin
      r.val = v[31:0];
      r.over = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      5'd31: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

FILE: design/vpr_front.sv
// Operation select, degree-to-turn conversion and gain pre-scaling, four stages.
module vpr_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [2:0]         req_type,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] factor,
  output logic               out_valid,
  output vpr_pkg::rot_t      out_data
);
  import vpr_pkg::*;

  localparam int DSH = 32 - FRAC_BITS;
  localparam logic signed [63:0] SCALE_HALF = 64'sd1 <<< (FRAC_BITS - 1);

  req_t               req;
  logic signed [33:0] mul_b;
  logic signed [63:0] p_x_c;
  logic signed [63:0] p_y_c;
  logic [31:0]        mag_c;
  logic [58:0]        q1p_c;
  logic signed [31:0] rx_c;
  logic signed [31:0] ry_c;
  logic               sat_c;
  logic               bad_c;
  sat_t               sa_x;
  sat_t               sa_y;

  logic               v1;
  req_t               req1;
  logic signed [63:0] p_x1;
  logic signed [63:0] p_y1;
  logic [31:0]        mag1;
  logic [58:0]        q1p1;
  logic               neg1;
  logic signed [31:0] rx1;
  logic signed [31:0] ry1;
  logic               sat1;
  logic               bad1;

  logic [23:0]        q1_c;
  logic [31:0]        r_full;
  logic [29:0]        a2_c;
  sat_t               sc_x;
  sat_t               sc_y;

  logic               v2;
  logic               pol2;
  logic signed [63:0] p2;
  logic [23:0]        q1_2;
  logic [29:0]        a2;
  logic               neg2;
  logic signed [31:0] rx2;
  logic signed [31:0] ry2;
  logic               sat2;
  logic               bad2;

  logic               v3;
  logic               pol3;
  logic signed [63:0] p3;
  logic signed [63:0] np3;
  logic [23:0]        q1_3;
  logic [60:0]        q2p3;
  logic               neg3;
  logic signed [31:0] rx3;
  logic signed [31:0] ry3;
  logic               sat3;
  logic               bad3;

  logic [24:0]              q2_c;
  logic [31:0]              qsum;
  logic [31:0]              u_c;
  logic signed [TURN_W-1:0] t0;
  logic signed [TURN_W-1:0] t1;
  logic                     flip;
  logic signed [63:0]       pm;
  rot_t                     nxt;

  // stage 1: products, degree magnitude, simple operations
  assign req = req_t'(req_type);
  assign mul_b = (req == REQ_POLAR) ? GAIN_INV_Q32 : 34'(factor);
  assign p_x_c = a_x * mul_b;
  assign p_y_c = a_y * factor;
  assign mag_c = a_y[31] ? (32'd0 - a_y) : a_y;
  assign q1p_c = mag_c[31:3] * DIV45_M1;

  always_comb begin
    rx_c = '0;
    ry_c = '0;
    sat_c = 1'b0;
    bad_c = 1'b0;
    sa_x = '0;
    sa_y = '0;
    unique case (req)
      REQ_RECT, REQ_MAGANG: begin
        rx_c = a_x;
        ry_c = a_y;
      end
      REQ_ADD: begin
        sa_x = clamp32(64'(a_x) + 64'(b_x));
        sa_y = clamp32(64'(a_y) + 64'(b_y));
        rx_c = sa_x.val;
        ry_c = sa_y.val;
        sat_c = sa_x.over | sa_y.over;
      end
      REQ_SUB: begin
        sa_x = clamp32(64'(a_x) - 64'(b_x));
        sa_y = clamp32(64'(a_y) - 64'(b_y));
        rx_c = sa_x.val;
        ry_c = sa_y.val;
        sat_c = sa_x.over | sa_y.over;
      end
      REQ_NEG: begin
        sa_x = clamp32(-64'(a_x));
        sa_y = clamp32(-64'(a_y));
        rx_c = sa_x.val;
        ry_c = sa_y.val;
        sat_c = sa_x.over | sa_y.over;
      end
      REQ_POLAR, REQ_SCALE: begin
        rx_c = '0;
        ry_c = '0;
      end
      REQ_INVALID: begin
        bad_c = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    req1 <= req;
    p_x1 <= p_x_c;
    p_y1 <= p_y_c;
    mag1 <= mag_c;
    q1p1 <= q1p_c;
    neg1 <= a_y[31];
    rx1 <= rx_c;
    ry1 <= ry_c;
    sat1 <= sat_c;
    bad1 <= bad_c;
  end

  // stage 2: degree remainder, scale rounding
  assign q1_c = q1p1[58:DIV45_S1];
  assign r_full = mag1 - 32'(q1_c) * 32'd360;
  assign a2_c = (30'(r_full[8:0]) << (DSH - 3)) + 30'd22;
  assign sc_x = clamp32((p_x1 + SCALE_HALF) >>> FRAC_BITS);
  assign sc_y = clamp32((p_y1 + SCALE_HALF) >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    pol2 <= (req1 == REQ_POLAR);
    p2 <= p_x1;
    q1_2 <= q1_c;
    a2 <= a2_c;
    neg2 <= neg1;
    if (req1 == REQ_SCALE) begin
      rx2 <= sc_x.val;
      ry2 <= sc_y.val;
      sat2 <= sat1 | sc_x.over | sc_y.over;
    end else begin
      rx2 <= rx1;
      ry2 <= ry1;
      sat2 <= sat1;
    end
    bad2 <= bad1;
  end

  // stage 3: second reciprocal product
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    pol3 <= pol2;
    p3 <= p2;
    np3 <= -p2;
    q1_3 <= q1_2;
    q2p3 <= a2 * DIV45_M2;
    neg3 <= neg2;
    rx3 <= rx2;
    ry3 <= ry2;
    sat3 <= sat2;
    bad3 <= bad2;
  end

  // stage 4: turn angle, half-plane fold, CORDIC start vector
  assign q2_c = q2p3[60:DIV45_S2];
  assign qsum = (32'(q1_3) << DSH) + 32'(q2_c);
  assign u_c = neg3 ? (32'd0 - qsum) : qsum;
  assign t0 = TURN_W'($signed(u_c));

  always_comb begin
    if (t0 > TURN_QUARTER) begin
      t1 = t0 - TURN_HALF;
      flip = 1'b1;
    end else if (t0 < -TURN_QUARTER) begin
      t1 = t0 + TURN_HALF;
      flip = 1'b1;
    end else begin
      t1 = t0;
      flip = 1'b0;
    end
    pm = flip ? np3 : p3;
    nxt.bad = bad3;
    nxt.sat = sat3;
    if (pol3) begin
      nxt.bypass = 1'b0;
      nxt.x = ROT_W'(pm >>> (32 - EXTRA_BITS));
      nxt.y = '0;
      nxt.t = t1;
    end else begin
      nxt.bypass = 1'b1;
      nxt.x = ROT_W'(rx3) <<< EXTRA_BITS;
      nxt.y = ROT_W'(ry3) <<< EXTRA_BITS;
      nxt.t = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v3;
    end
    out_data <= nxt;
  end

endmodule

FILE: design/vpr_rotate.sv
// Rotation-mode CORDIC pipeline, one iteration per stage, then rounding and saturation.
module vpr_rotate #(
  parameter int STAGES = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  vpr_pkg::rot_t in_data,
  output logic          out_valid,
  output vpr_pkg::vec_t out_data
);
  import vpr_pkg::*;

  localparam logic signed [ROT_W-1:0] ROUND = ROT_W'(1) <<< (EXTRA_BITS - 1);

  rot_t pipe [1:STAGES];
  logic pv   [1:STAGES];
  sat_t ox;
  sat_t oy;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    rot_t                    src;
    rot_t                    nxt;
    logic                    src_v;
    logic signed [ROT_W-1:0] dx;
    logic signed [ROT_W-1:0] dy;
    logic [31:0]             at;

    if (k == 0) begin : g_first
      assign src = in_data;
      assign src_v = in_valid;
    end else begin : g_rest
      assign src = pipe[k];
      assign src_v = pv[k];
    end

    assign dx = src.y >>> k;
    assign dy = src.x >>> k;
    assign at = atan_turn(5'(k));

    always_comb begin
      nxt = src;
      if (!src.bypass) begin
        if (src.t >= 0) begin
          nxt.x = src.x - dx;
          nxt.y = src.y + dy;
          nxt.t = src.t - $signed(TURN_W'(at));
        end else begin
          nxt.x = src.x + dx;
          nxt.y = src.y - dy;
          nxt.t = src.t + $signed(TURN_W'(at));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pv[k+1] <= 1'b0;
      end else begin
        pv[k+1] <= src_v;
      end
      pipe[k+1] <= nxt;
    end
  end

  // round off the guard bits and saturate
  assign ox = clamp32(64'((pipe[STAGES].x + ROUND) >>> EXTRA_BITS));
  assign oy = clamp32(64'((pipe[STAGES].y + ROUND) >>> EXTRA_BITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= pv[STAGES];
    end
    out_data.bad <= pipe[STAGES].bad;
    out_data.sat <= pipe[STAGES].sat | ox.over | oy.over;
    out_data.x <= ox.val;
    out_data.y <= oy.val;
  end

endmodule

FILE: design/vpr_measure.sv
// Magnitude by pipelined square root and angle by vectoring CORDIC, with result registers.
module vpr_measure #(
  parameter int FRAC_BITS = 16,
  parameter int STAGES    = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  vpr_pkg::vec_t      in_data,
  output logic               done,
  output logic signed [31:0] res_x,
  output logic signed [31:0] res_y,
  output logic [30:0]        res_mag,
  output logic signed [18:0] res_angle,
  output logic [1:0]         status
);
  import vpr_pkg::*;

  localparam int RAD_SH = 59 - FRAC_BITS;
  localparam logic signed [63:0] RAD_HALF = 64'sd1 <<< (RAD_SH - 1);

  typedef struct packed {
    logic                     ypos;
    logic                     yneg;
    logic                     fixed;
    logic signed [TURN_W-1:0] base;
    logic signed [VEC_W-1:0]  vx;
    logic signed [VEC_W-1:0]  vy;
    logic signed [TURN_W-1:0] z;
  } ang_t;

  typedef struct packed {
    vec_t                 v;
    ang_t                 a;
    logic [ROOT_BITS-1:0] root;
    logic [64:0]          rem;
  } msr_t;

  ang_t               ang_c;
  logic signed [63:0] sqx_c;
  logic signed [63:0] sqy_c;

  logic               v1;
  vec_t               vec1;
  ang_t               ang1;
  logic [63:0]        sqx1;
  logic [63:0]        sqy1;

  logic               v2;
  msr_t               m2;

  msr_t               pipe [1:ROOT_BITS];
  logic               pv   [1:ROOT_BITS];

  msr_t                     last;
  logic [32:0]              mag_c;
  logic signed [TURN_W-1:0] tot_c;
  logic signed [TURN_W-1:0] tot_s;

  logic                     v3;
  vec_t                     vec3;
  logic [30:0]              mag3;
  logic                     over3;
  logic signed [TURN_W-1:0] tot3;

  logic                     v4;
  vec_t                     vec4;
  logic [30:0]              mag4;
  logic                     over4;
  logic signed [63:0]       prod4;
  logic signed [63:0]       ang_full;

  // stage 1: squares and angle setup
  assign sqx_c = in_data.x * in_data.x;
  assign sqy_c = in_data.y * in_data.y;

  always_comb begin
    ang_c.ypos = (in_data.y > 0);
    ang_c.yneg = (in_data.y < 0);
    ang_c.fixed = (in_data.x == 0) || (in_data.y == 0);
    ang_c.z = '0;
    priority if (in_data.x == 0 && in_data.y == 0) begin
      ang_c.base = '0;
    end else if (in_data.y == 0) begin
      ang_c.base = (in_data.x > 0) ? '0 : TURN_HALF;
    end else if (in_data.x == 0) begin
      ang_c.base = (in_data.y > 0) ? TURN_QUARTER : -TURN_QUARTER;
    end else if (in_data.x < 0) begin
      ang_c.base = (in_data.y > 0) ? TURN_HALF : -TURN_HALF;
    end else begin
      ang_c.base = '0;
    end
    if (in_data.x < 0) begin
      ang_c.vx = (-VEC_W'(in_data.x)) <<< EXTRA_BITS;
      ang_c.vy = (-VEC_W'(in_data.y)) <<< EXTRA_BITS;
    end else begin
      ang_c.vx = VEC_W'(in_data.x) <<< EXTRA_BITS;
      ang_c.vy = VEC_W'(in_data.y) <<< EXTRA_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    vec1 <= in_data;
    ang1 <= ang_c;
    sqx1 <= sqx_c;
    sqy1 <= sqy_c;
  end

  // stage 2: sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    m2.v <= vec1;
    m2.a <= ang1;
    m2.root <= '0;
    m2.rem <= 65'(sqx1) + 65'(sqy1);
  end

  // one root bit per stage, and one CORDIC iteration in each of the first STAGES stages
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    localparam int B = ROOT_BITS - 1 - k;
    msr_t                    src;
    msr_t                    nxt;
    logic                    src_v;
    logic [64:0]             trial;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    logic [31:0]             at;

    if (k == 0) begin : g_first
      assign src = m2;
      assign src_v = v2;
    end else begin : g_rest
      assign src = pipe[k];
      assign src_v = pv[k];
    end

    assign trial = (65'(src.root) << (B + 1)) | (65'(1) << (2 * B));
    assign dx = src.a.vy >>> k;
    assign dy = src.a.vx >>> k;
    assign at = atan_turn(5'(k));

    always_comb begin
      nxt = src;
      if (src.rem >= trial) begin
        nxt.rem = src.rem - trial;
        nxt.root = src.root | (ROOT_BITS'(1) << B);
      end
      if (k < STAGES && !src.a.fixed) begin
        if (src.a.vy > 0) begin
          nxt.a.vx = src.a.vx + dx;
          nxt.a.vy = src.a.vy - dy;
          nxt.a.z = src.a.z + $signed(TURN_W'(at));
        end else begin
          nxt.a.vx = src.a.vx - dx;
          nxt.a.vy = src.a.vy + dy;
          nxt.a.z = src.a.z - $signed(TURN_W'(at));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pv[k+1] <= 1'b0;
      end else begin
        pv[k+1] <= src_v;
      end
      pipe[k+1] <= nxt;
    end
  end

  // stage 3: round the root, clamp the turn angle
  assign last = pipe[ROOT_BITS];
  assign mag_c = 33'(last.root) + 33'(last.rem > 65'(last.root));
  assign tot_c = last.a.base + last.a.z;

  always_comb begin
    if (tot_c > TURN_HALF) begin
      tot_s = TURN_HALF;
    end else if (tot_c < -TURN_HALF) begin
      tot_s = -TURN_HALF;
    end else begin
      tot_s = tot_c;
    end
    if (last.a.ypos && tot_s < 0) begin
      tot_s = '0;
    end
    if (last.a.yneg && tot_s > 0) begin
      tot_s = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= pv[ROOT_BITS];
    end
    vec3 <= last.v;
    if (mag_c > 33'h07fffffff) begin
      mag3 <= 31'h7fffffff;
      over3 <= 1'b1;
    end else begin
      mag3 <= mag_c[30:0];
      over3 <= 1'b0;
    end
    tot3 <= tot_s;
  end

  // stage 4: turns to radians product
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    vec4 <= vec3;
    mag4 <= mag3;
    over4 <= over3;
    prod4 <= tot3 * PI_Q28;
  end

  // stage 5: result registers
  assign ang_full = (prod4 + RAD_HALF) >>> RAD_SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v4;
    end
    res_x <= vec4.x;
    res_y <= vec4.y;
    res_mag <= mag4;
    res_angle <= ang_full[18:0];
    if (vec4.bad) begin
      status <= STATUS_INVALID;
    end else if (vec4.sat || over4) begin
      status <= STATUS_SAT;
    end else begin
      status <= STATUS_OK;
    end
  end

endmodule

FILE: design/vector_polar_rect_unit.sv
// Top level of the vector polar/rectangular unit.
//
// A transaction is accepted at a rising edge with start high and busy low.
// busy is always low: the unit is fully pipelined and takes one transaction
// per clock cycle. req_type picks the operation on (a_x, a_y), (b_x, b_y) and
// factor, all signed fixed point with FRAC_BITS fraction bits.
// Each transaction gives one result: res_x, res_y, res_mag, res_angle and
// status are valid for exactly one cycle while done is high, once the
// transaction has passed the front end, rotation and measurement pipelines.
// The depth is set by the rotation CORDIC (CORDIC_STAGES stages) in series
// with the 32-stage square root that runs alongside the vectoring CORDIC.
// Results leave in order of acceptance; the receiver must take each result
// in its done cycle, since it cannot stall the unit.
// Synchronous reset clears all valid bits, so no done pulse follows reset
// until new transactions have been accepted.
module vector_polar_rect_unit #(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         req_type,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] factor,
  output logic               done,
  output logic signed [31:0] res_x,
  output logic signed [31:0] res_y,
  output logic [30:0]        res_mag,
  output logic signed [18:0] res_angle,
  output logic [1:0]         status
);
  import vpr_pkg::*;

  logic accept;
  logic front_valid;
  rot_t front_data;
  logic rot_valid;
  vec_t rot_data;

  assign busy = 1'b0;
  assign accept = start & ~busy;

  vpr_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .req_type (req_type),
    .a_x      (a_x),
    .a_y      (a_y),
    .b_x      (b_x),
    .b_y      (b_y),
    .factor   (factor),
    .out_valid(front_valid),
    .out_data (front_data)
  );

  vpr_rotate #(
    .STAGES(CORDIC_STAGES)
  ) u_rotate (
    .clk      (clk),
    .rst      (rst),
    .in_valid (front_valid),
    .in_data  (front_data),
    .out_valid(rot_valid),
    .out_data (rot_data)
  );

  vpr_measure #(
    .FRAC_BITS(FRAC_BITS),
    .STAGES   (CORDIC_STAGES)
  ) u_measure (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rot_valid),
    .in_data  (rot_data),
    .done     (done),
    .res_x    (res_x),
    .res_y    (res_y),
    .res_mag  (res_mag),
    .res_angle(res_angle),
    .status   (status)
  );

endmodule

FILE: bench/tb.sv
// Self-checking bench for vector_polar_rect_unit: directed and random requests against a predictor.
`timescale 1ns / 1ps

module tb;
  import vpr_pkg::*;

  localparam int FB = 16;
  localparam int NSTAGE = 24;
  localparam int LAT = 42 + NSTAGE;
  localparam longint HALF_T = 64'sd2147483648;
  localparam longint QUART_T = 64'sd1073741824;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        mag;
    logic signed [18:0] ang;
    logic [1:0]         st;
  } vec_result_t;

  class result_board;
    vec_result_t pending[$];
    int errors = 0;
    int checked = 0;
    int per_op[8];
    bit [31:0] turn_tab[32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000};

    function longint clip32(longint v, ref bit ovf);
      if (v > 64'sd2147483647) begin
        ovf = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        ovf = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint turns_to_rad(longint t);
      return (t * 64'sd843314857 + (64'sd1 <<< (58 - FB))) >>> (59 - FB);
    endfunction

    function longint unsigned root_round(longint unsigned s);
      longint unsigned rem, res, one;
      rem = s;
      res = 0;
      one = 64'd1 << 62;
      while (one > rem) one = one >> 2;
      while (one != 0) begin
        if (rem >= res + one) begin
          rem = rem - (res + one);
          res = (res >> 1) + one;
        end else begin
          res = res >> 1;
        end
        one = one >> 2;
      end
      if (s - res * res > res) res++;
      return res;
    endfunction

    function longint atan2_rad(longint x, longint y);
      longint base, vx, vy, z, total, dx, dy;
      base = 0;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (y == 0) return x > 0 ? 0 : turns_to_rad(HALF_T);
      if (x == 0) return turns_to_rad(y > 0 ? QUART_T : -QUART_T);
      vx = x;
      vy = y;
      if (x < 0) begin
        vx = -x;
        vy = -y;
        base = y > 0 ? HALF_T : -HALF_T;
      end
      vx = vx * 65536;
      vy = vy * 65536;
      for (int i = 0; i < NSTAGE; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (vy > 0) begin
          vx += dx; vy -= dy; z += longint'({32'd0, turn_tab[i]});
        end else begin
          vx -= dx; vy += dy; z -= longint'({32'd0, turn_tab[i]});
        end
      end
      total = base + z;
      if (total > HALF_T) total = HALF_T;
      if (total < -HALF_T) total = -HALF_T;
      if (y > 0 && total < 0) total = 0;
      if (y < 0 && total > 0) total = 0;
      return turns_to_rad(total);
    endfunction

    function void rotate_polar(longint m, longint deg, ref longint ox, ref longint oy,
                               ref bit ovf);
      longint amag, q, u, t, x, y, dx, dy;
      amag = deg < 0 ? -deg : deg;
      q = ((amag <<< (32 - FB)) + 180) / 360;
      u = (deg < 0 ? -q : q) & 64'hFFFFFFFF;
      t = u >= HALF_T ? u - 64'sd4294967296 : u;
      if (t > QUART_T) begin
        t -= HALF_T; m = -m;
      end else if (t < -QUART_T) begin
        t += HALF_T; m = -m;
      end
      x = (m * 64'sd2608131496) >>> 16;
      y = 0;
      for (int i = 0; i < NSTAGE; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (t >= 0) begin
          x -= dx; y += dy; t -= longint'({32'd0, turn_tab[i]});
        end else begin
          x += dx; y -= dy; t += longint'({32'd0, turn_tab[i]});
        end
      end
      ox = clip32((x + 64'sd32768) >>> 16, ovf);
      oy = clip32((y + 64'sd32768) >>> 16, ovf);
    endfunction

    function void note_request(req_t op, logic signed [31:0] ax, logic signed [31:0] ay,
                               logic signed [31:0] bx, logic signed [31:0] by,
                               logic signed [31:0] f);
      longint rx, ry, half;
      longint unsigned m;
      bit ovf, bad;
      vec_result_t e;
      rx = 0; ry = 0; ovf = 0; bad = 0;
      half = 64'sd1 <<< (FB - 1);
      per_op[op]++;
      case (op)
        REQ_RECT, REQ_MAGANG: begin rx = ax; ry = ay; end
        REQ_POLAR: rotate_polar(ax, ay, rx, ry, ovf);
        REQ_ADD: begin
          rx = clip32(longint'(ax) + bx, ovf); ry = clip32(longint'(ay) + by, ovf);
        end
        REQ_SUB: begin
          rx = clip32(longint'(ax) - bx, ovf); ry = clip32(longint'(ay) - by, ovf);
        end
        REQ_NEG: begin rx = clip32(-longint'(ax), ovf); ry = clip32(-longint'(ay), ovf); end
        REQ_SCALE: begin
          rx = clip32((longint'(ax) * f + half) >>> FB, ovf);
          ry = clip32((longint'(ay) * f + half) >>> FB, ovf);
        end
        default: bad = 1;
      endcase
      m = root_round(longint'(rx * rx) + longint'(ry * ry));
      if (m > 64'd2147483647) begin
        m = 64'd2147483647; ovf = 1;
      end
      e.x = rx[31:0];
      e.y = ry[31:0];
      e.mag = m[30:0];
      e.ang = 19'(atan2_rad(rx, ry));
      e.st = bad ? STATUS_INVALID : (ovf ? STATUS_SAT : STATUS_OK);
      pending.push_back(e);
    endfunction

    function void check_result(vec_result_t a);
      vec_result_t e;
      if (pending.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (a.x !== e.x) begin $error("res_x exp %0d got %0d", e.x, a.x); errors++; end
      if (a.y !== e.y) begin $error("res_y exp %0d got %0d", e.y, a.y); errors++; end
      if (a.mag !== e.mag) begin $error("res_mag exp %0d got %0d", e.mag, a.mag); errors++; end
      if (a.ang !== e.ang) begin
        $error("res_angle exp %0d got %0d", e.ang, a.ang); errors++;
      end
      if (a.st !== e.st) begin $error("status exp %0d got %0d", e.st, a.st); errors++; end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [2:0] req_type = '0;
  logic signed [31:0] a_x = '0, a_y = '0, b_x = '0, b_y = '0, factor = '0;
  logic busy, done;
  logic signed [31:0] res_x, res_y;
  logic [30:0] res_mag;
  logic signed [18:0] res_angle;
  logic [1:0] status;

  result_board board = new();
  bit no_gaps = 0;

  vector_polar_rect_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y), .factor(factor),
    .done(done), .res_x(res_x), .res_y(res_y), .res_mag(res_mag),
    .res_angle(res_angle), .status(status));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    vec_result_t got;
    if (!rst && done) begin
      got.x = res_x; got.y = res_y; got.mag = res_mag; got.ang = res_angle; got.st = status;
      board.check_result(got);
    end
  end

  task automatic issue(req_t op, logic signed [31:0] ax, logic signed [31:0] ay,
                       logic signed [31:0] bx, logic signed [31:0] by,
                       logic signed [31:0] f);
    int gap;
    start <= 1'b1;
    req_type <= op;
    a_x <= ax; a_y <= ay; b_x <= bx; b_y <= by; factor <= f;
    do @(posedge clk); while (busy);
    board.note_request(op, ax, ay, bx, by, f);
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $urandom_range(0, 1) ? $urandom_range(0, 32'h40000)
                                     : -$urandom_range(0, 32'h40000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_degrees();
    logic signed [31:0] d;
    d = $urandom_range(0, 720 * 65536);
    return $urandom_range(0, 1) ? d : -d;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(REQ_RECT, 32'sh7fffffff, 32'sh80000000, 0, 0, 0);
    issue(REQ_RECT, 32'sh80000000, 32'sh80000000, 0, 0, 0);
    issue(REQ_MAGANG, 0, 0, 0, 0, 0);
    issue(REQ_MAGANG, -5 * 65536, 0, 0, 0, 0);
    issue(REQ_MAGANG, 0, -3 * 65536, 0, 0, 0);
    issue(REQ_MAGANG, -65536, -1, 0, 0, 0);
    issue(REQ_POLAR, 10 * 65536, 90 * 65536, 0, 0, 0);
    issue(REQ_POLAR, 10 * 65536, -90 * 65536, 0, 0, 0);
    issue(REQ_POLAR, 10 * 65536, 180 * 65536, 0, 0, 0);
    issue(REQ_POLAR, -7 * 65536, 30 * 65536, 0, 0, 0);
    issue(REQ_POLAR, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0);
    issue(REQ_POLAR, 32'sh80000000, 32'sh80000000, 0, 0, 0);
    issue(REQ_POLAR, 3 * 65536, 405 * 65536, 0, 0, 0);
    issue(REQ_ADD, 32'sh7fffffff, 32'sh80000000, 1, -1, 0);
    issue(REQ_ADD, 5, 6, -5, -6, 0);
    issue(REQ_SUB, 32'sh80000000, 32'sh7fffffff, 1, -1, 0);
    issue(REQ_NEG, 32'sh80000000, 32'sh7fffffff, 0, 0, 0);
    issue(REQ_SCALE, 32'sh7fffffff, 32'sh80000000, 0, 0, 32'sh7fffffff);
    issue(REQ_SCALE, 32'sh80000000, -3, 0, 0, 32'sh80000000);
    issue(REQ_SCALE, 3, -3, 0, 0, 32'sh00008000);
    issue(REQ_INVALID, 32'sh12345678, -1, -1, -1, -1);
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);

    for (int n = 0; n < 500; n++) begin
      req_t op;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      if (n >= 420) no_gaps = 1;
      else if ($urandom_range(0, 15) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      op = req_t'($urandom_range(0, 7));
      ax = pick32();
      ay = (op == REQ_POLAR && $urandom_range(0, 3) != 0) ? pick_degrees() : pick32();
      issue(op, ax, ay, pick32(), pick32(), pick32());
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);

    $display("checked %0d results over %0d operation types", board.checked, 8);
    $display("per type: %0d %0d %0d %0d %0d %0d %0d %0d", board.per_op[0], board.per_op[1],
             board.per_op[2], board.per_op[3], board.per_op[4], board.per_op[5],
             board.per_op[6], board.per_op[7]);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("[vector_polar_rect_unit] OK");
    else
      $display("[vector_polar_rect_unit] ERROR");
    $finish;
  end

  initial begin
    #2ms;
    $display("[vector_polar_rect_unit] ERROR");
    $finish;
  end

endmodule
